// ===== src/htri_pkg.sv =====
// ----------------------------------------------------------------------------
// htri_pkg: shared constants and types
// Grid geometry, fixed-point widths, request codes and the structs passed
// between the front end, the height memories and the solve pipeline.
// ----------------------------------------------------------------------------
package htri_pkg;

  localparam int GridCells  = 128;
  localparam int CellBits   = $clog2(GridCells);
  localparam int CellMax    = GridCells - 1;
  localparam int CornerSide = GridCells + 1;
  localparam int FracBits   = 8;
  localparam int HeightBits = 32;
  localparam int IdxBits    = 8;
  localparam int QueryBits  = 16;
  localparam int Unit       = 1 << FracBits;
  localparam int Half       = Unit / 2;

  localparam int CornerDepth   = CornerSide * CornerSide;
  localparam int CornerIdxBits = $clog2(CornerDepth);
  localparam int BankDepth     = (CornerDepth + 1) / 2;
  localparam int BankAddrBits  = $clog2(BankDepth);
  localparam int CenterDepth   = GridCells * GridCells;
  localparam int CenterAddrBits = $clog2(CenterDepth);

  localparam int OffBits  = QueryBits + 1;
  localparam int DiffBits = HeightBits + 2;
  localparam int ProdBits = DiffBits + OffBits;
  localparam int AccBits  = ProdBits + 3;

  localparam logic signed [AccBits-1:0] AccHeightMax =
    (AccBits'(1) <<< (HeightBits - 1)) - AccBits'(1);
  localparam logic signed [AccBits-1:0] AccHeightMin = -AccHeightMax - AccBits'(1);

  typedef enum logic [1:0] {
    REQ_CORNER = 2'd0,
    REQ_CENTER = 2'd1,
    REQ_QUERY  = 2'd2
  } req_type_e;

  typedef struct packed {
    logic                      is_query;
    logic                      range_error;
    logic                      sel_right;
    logic                      sel_far;
    logic                      swap;
    logic signed [OffBits-1:0] ex;
    logic signed [OffBits-1:0] ez;
  } item_ctl_t;

  typedef struct packed {
    logic                      center_we;
    logic [CenterAddrBits-1:0] center_waddr;
    logic [CenterAddrBits-1:0] center_raddr;
    logic [1:0]                bank_we;
    logic [BankAddrBits-1:0]   bank_waddr;
    logic [BankAddrBits-1:0]   bank0_raddr;
    logic [BankAddrBits-1:0]   bank1_raddr;
    logic [HeightBits-1:0]     wdata;
  } mem_cmd_t;

endpackage

// ===== src/htri_req_if.sv =====
// ----------------------------------------------------------------------------
// htri_req_if: request channel
// Valid/ready channel carrying height writes and height queries.
// ----------------------------------------------------------------------------
interface htri_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             req_type;
  logic [htri_pkg::IdxBits-1:0]           grid_x;
  logic [htri_pkg::IdxBits-1:0]           grid_z;
  logic signed [htri_pkg::HeightBits-1:0] height_value;
  logic [htri_pkg::QueryBits-1:0]         query_x;
  logic [htri_pkg::QueryBits-1:0]         query_z;

  modport source (
    output valid, req_type, grid_x, grid_z, height_value, query_x, query_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, grid_x, grid_z, height_value, query_x, query_z,
    output ready
  );
endinterface

// ===== src/htri_rsp_if.sv =====
// ----------------------------------------------------------------------------
// htri_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface htri_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [htri_pkg::HeightBits-1:0] height_out;
  logic                                   is_answer;
  logic                                   range_error;

  modport source (
    output valid, height_out, is_answer, range_error,
    input  ready
  );
  modport sink (
    input  valid, height_out, is_answer, range_error,
    output ready
  );
endinterface

// ===== src/htri_ram.sv =====
// ----------------------------------------------------------------------------
// htri_ram: simple dual-port synchronous RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module htri_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/htri_front.sv =====
// ----------------------------------------------------------------------------
// htri_front: request decode and address generation
// Range-checks writes, locates the query cell, picks the triangle and maps
// the three needed heights onto the center memory and two corner banks.
// ----------------------------------------------------------------------------
module htri_front (
  input  logic                                   accept_i,
  input  logic [1:0]                             req_type_i,
  input  logic [htri_pkg::IdxBits-1:0]           grid_x_i,
  input  logic [htri_pkg::IdxBits-1:0]           grid_z_i,
  input  logic signed [htri_pkg::HeightBits-1:0] height_value_i,
  input  logic [htri_pkg::QueryBits-1:0]         query_x_i,
  input  logic [htri_pkg::QueryBits-1:0]         query_z_i,
  output htri_pkg::mem_cmd_t                     cmd_o,
  output htri_pkg::item_ctl_t                    ctl_o
);

  localparam int CiB = htri_pkg::CornerIdxBits;
  localparam int CB  = htri_pkg::CellBits;
  localparam int QB  = htri_pkg::QueryBits;
  localparam int FB  = htri_pkg::FracBits;
  localparam int OB  = htri_pkg::OffBits;

  logic            is_corner, is_center, is_query;
  logic            corner_ok, center_ok;
  logic [CiB-1:0]  widx;
  logic [QB-FB-1:0] qcx, qcz;
  logic [CB-1:0]   xc, zc;
  logic [QB-1:0]   lx, lz;
  logic            sel_right, sel_far;
  logic [CiB-1:0]  base, h1_idx, h2_idx;
  logic            swap;

  assign is_corner = (req_type_i == htri_pkg::REQ_CORNER);
  assign is_center = (req_type_i == htri_pkg::REQ_CENTER);
  assign is_query  = (req_type_i == htri_pkg::REQ_QUERY);

  assign corner_ok = (grid_x_i <= htri_pkg::IdxBits'(htri_pkg::GridCells)) &&
                     (grid_z_i <= htri_pkg::IdxBits'(htri_pkg::GridCells));
  assign center_ok = (grid_x_i < htri_pkg::IdxBits'(htri_pkg::GridCells)) &&
                     (grid_z_i < htri_pkg::IdxBits'(htri_pkg::GridCells));

  assign widx = CiB'(grid_x_i) * CiB'(htri_pkg::CornerSide) + CiB'(grid_z_i);

  // cell index, clamped to the last cell
  assign qcx = query_x_i[QB-1:FB];
  assign qcz = query_z_i[QB-1:FB];
  assign xc  = (qcx > (QB-FB)'(htri_pkg::CellMax)) ? CB'(htri_pkg::CellMax) : qcx[CB-1:0];
  assign zc  = (qcz > (QB-FB)'(htri_pkg::CellMax)) ? CB'(htri_pkg::CellMax) : qcz[CB-1:0];

  assign lx = query_x_i - QB'({xc, {FB{1'b0}}});
  assign lz = query_z_i - QB'({zc, {FB{1'b0}}});

  assign sel_right = (lx > lz);
  assign sel_far   = ((QB+1)'(lx) + (QB+1)'(lz)) > (QB+1)'(htri_pkg::Unit);

  assign base   = CiB'(xc) * CiB'(htri_pkg::CornerSide) + CiB'(zc);
  assign h1_idx = sel_right ? base + CiB'(htri_pkg::CornerSide) : base + CiB'(1);
  assign h2_idx = sel_far ? base + CiB'(htri_pkg::CornerSide + 1) : base;
  // h2 lives in the bank of the base parity, h1 in the other one
  assign swap   = base[0];

  always_comb begin
    cmd_o.center_we    = accept_i && is_center && center_ok;
    cmd_o.center_waddr = {grid_x_i[CB-1:0], grid_z_i[CB-1:0]};
    cmd_o.center_raddr = {xc, zc};
    cmd_o.bank_we[0]   = accept_i && is_corner && corner_ok && !widx[0];
    cmd_o.bank_we[1]   = accept_i && is_corner && corner_ok && widx[0];
    cmd_o.bank_waddr   = widx[CiB-1:1];
    cmd_o.bank0_raddr  = swap ? h1_idx[CiB-1:1] : h2_idx[CiB-1:1];
    cmd_o.bank1_raddr  = swap ? h2_idx[CiB-1:1] : h1_idx[CiB-1:1];
    cmd_o.wdata        = height_value_i;

    ctl_o.is_query    = is_query;
    ctl_o.range_error = (is_corner && !corner_ok) || (is_center && !center_ok);
    ctl_o.sel_right   = sel_right;
    ctl_o.sel_far     = sel_far;
    ctl_o.swap        = swap;
    ctl_o.ex          = OB'(lx) - OB'(htri_pkg::Half);
    ctl_o.ez          = OB'(lz) - OB'(htri_pkg::Half);
  end

endmodule

// ===== src/htri_solve.sv =====
// ----------------------------------------------------------------------------
// htri_solve: plane solve pipeline
// Takes the three read heights, forms the plane slopes, multiplies by the
// offsets, accumulates, truncates toward zero and saturates.
// ----------------------------------------------------------------------------
module htri_solve (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  htri_pkg::item_ctl_t               ctl_i,
  input  logic [htri_pkg::HeightBits-1:0]   center_i,
  input  logic [htri_pkg::HeightBits-1:0]   bank0_i,
  input  logic [htri_pkg::HeightBits-1:0]   bank1_i,
  output logic                              ready_o,
  htri_rsp_if.source                        rsp_o
);

  localparam int HB  = htri_pkg::HeightBits;
  localparam int DB  = htri_pkg::DiffBits;
  localparam int PB  = htri_pkg::ProdBits;
  localparam int AB  = htri_pkg::AccBits;
  localparam int FB  = htri_pkg::FracBits;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  htri_pkg::item_ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;

  // stage 1: read data
  logic signed [HB-1:0] h0, h1, h2;
  logic signed [DB-1:0] dy1, dy2, sum, dif;
  logic signed [DB-1:0] p_d, q_d;
  // stage 2
  logic signed [DB-1:0] p_q, q_q;
  logic signed [HB-1:0] h0_q;
  // stage 3
  logic signed [PB-1:0] prodx_d, prodz_d, prodx_q, prodz_q;
  logic signed [AB-1:0] h0s_q;
  // stage 4
  logic signed [AB-1:0] acc_q;
  // stage 5
  logic signed [AB-1:0] trunc;
  logic signed [HB-1:0] sat;
  logic signed [HB-1:0] height_q;
  logic                 is_answer_q, range_error_q;

  assign rdy5    = !v5_q || rsp_o.ready;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= accept_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  assign h0  = $signed(center_i);
  assign h1  = ctl1_q.swap ? $signed(bank0_i) : $signed(bank1_i);
  assign h2  = ctl1_q.swap ? $signed(bank1_i) : $signed(bank0_i);
  assign dy1 = DB'(h1) - DB'(h0);
  assign dy2 = DB'(h2) - DB'(h0);
  assign sum = dy1 + dy2;
  assign dif = dy2 - dy1;

  always_comb begin
    case ({ctl1_q.sel_right, ctl1_q.sel_far})
      2'b11: begin
        p_d = sum;
        q_d = dif;
      end
      2'b10: begin
        p_d = -dif;
        q_d = -sum;
      end
      2'b01: begin
        p_d = dif;
        q_d = sum;
      end
      default: begin
        p_d = -sum;
        q_d = -dif;
      end
    endcase
  end

  assign prodx_d = PB'(p_q) * PB'($signed(ctl2_q.ex));
  assign prodz_d = PB'(q_q) * PB'($signed(ctl2_q.ez));

  assign trunc = acc_q[AB-1] ? ((acc_q + AB'(htri_pkg::Unit - 1)) >>> FB) : (acc_q >>> FB);

  always_comb begin
    if (trunc > htri_pkg::AccHeightMax) begin
      sat = HB'(htri_pkg::AccHeightMax);
    end else if (trunc < htri_pkg::AccHeightMin) begin
      sat = HB'(htri_pkg::AccHeightMin);
    end else begin
      sat = trunc[HB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ctl1_q <= ctl_i;
    end
    if (rdy2 && v1_q) begin
      ctl2_q <= ctl1_q;
      p_q    <= p_d;
      q_q    <= q_d;
      h0_q   <= h0;
    end
    if (rdy3 && v2_q) begin
      ctl3_q  <= ctl2_q;
      prodx_q <= prodx_d;
      prodz_q <= prodz_d;
      h0s_q   <= AB'(h0_q) <<< FB;
    end
    if (rdy4 && v3_q) begin
      ctl4_q <= ctl3_q;
      acc_q  <= AB'(prodx_q) + AB'(prodz_q) + h0s_q;
    end
    if (rdy5 && v4_q) begin
      height_q      <= ctl4_q.is_query ? sat : '0;
      is_answer_q   <= ctl4_q.is_query;
      range_error_q <= ctl4_q.range_error;
    end
  end

  assign rsp_o.valid       = v5_q;
  assign rsp_o.height_out  = height_q;
  assign rsp_o.is_answer   = is_answer_q;
  assign rsp_o.range_error = range_error_q;

endmodule

// ===== src/heightmap_triangle_interpolation_top.sv =====
// ----------------------------------------------------------------------------
// heightmap_triangle_interpolation_top: terrain height lookup
// Heightfield store with four-triangle plane interpolation of queries.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per transfer: a corner height write, a center
//   height write or an (x,z) query. rsp_o returns exactly one result per
//   request, in request order: the interpolated height (Q23.8, truncated
//   toward zero, saturated) for a query, zero height for writes, with a
//   range_error flag for writes outside the grid (those are dropped).
//   Each result passes the read, slope, product, sum and saturate registers
//   in turn. Throughput: one request per cycle while rsp_o is not stalled. A
//   query reads the center memory and both corner banks (split by lattice
//   parity) in the same cycle, one read port each; writes use the separate
//   write port. A write followed by a query of the same height is seen directly.
//   Reset clears the pipeline valid flags only; the height memories hold
//   garbage until written, and reading unwritten heights gives any value.
//   When rsp_o stalls the pipeline fills its empty stages first; req_i.ready
//   drops only when all five stages hold results.
// ----------------------------------------------------------------------------
module heightmap_triangle_interpolation_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  htri_req_if.sink   req_i,
  htri_rsp_if.source rsp_o
);

  logic                            accept;
  logic                            s1_ready;
  htri_pkg::mem_cmd_t              cmd;
  htri_pkg::item_ctl_t             ctl;
  logic [htri_pkg::HeightBits-1:0] center_rd, bank0_rd, bank1_rd;

  assign req_i.ready = s1_ready;
  assign accept      = req_i.valid && s1_ready;

  htri_front u_front (
    .accept_i       (accept),
    .req_type_i     (req_i.req_type),
    .grid_x_i       (req_i.grid_x),
    .grid_z_i       (req_i.grid_z),
    .height_value_i (req_i.height_value),
    .query_x_i      (req_i.query_x),
    .query_z_i      (req_i.query_z),
    .cmd_o          (cmd),
    .ctl_o          (ctl)
  );

  htri_ram #(
    .Depth (htri_pkg::CenterDepth),
    .Width (htri_pkg::HeightBits)
  ) u_center_ram (
    .clk_i   (clk_i),
    .we_i    (cmd.center_we),
    .waddr_i (cmd.center_waddr),
    .wdata_i (cmd.wdata),
    .re_i    (accept),
    .raddr_i (cmd.center_raddr),
    .rdata_o (center_rd)
  );

  htri_ram #(
    .Depth (htri_pkg::BankDepth),
    .Width (htri_pkg::HeightBits)
  ) u_bank0_ram (
    .clk_i   (clk_i),
    .we_i    (cmd.bank_we[0]),
    .waddr_i (cmd.bank_waddr),
    .wdata_i (cmd.wdata),
    .re_i    (accept),
    .raddr_i (cmd.bank0_raddr),
    .rdata_o (bank0_rd)
  );

  htri_ram #(
    .Depth (htri_pkg::BankDepth),
    .Width (htri_pkg::HeightBits)
  ) u_bank1_ram (
    .clk_i   (clk_i),
    .we_i    (cmd.bank_we[1]),
    .waddr_i (cmd.bank_waddr),
    .wdata_i (cmd.wdata),
    .re_i    (accept),
    .raddr_i (cmd.bank1_raddr),
    .rdata_o (bank1_rd)
  );

  htri_solve u_solve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ctl_i    (ctl),
    .center_i (center_rd),
    .bank0_i  (bank0_rd),
    .bank1_i  (bank1_rd),
    .ready_o  (s1_ready),
    .rsp_o    (rsp_o)
  );

endmodule

// ===== tb/height_checker.sv =====
// ----------------------------------------------------------------------------
// height_checker: request/response scoreboard for the terrain lookup
// Watches both channels, keeps its own copy of the corner and center height
// tables, works out the result owed for each request transfer and compares
// every response transfer with the oldest one owed, field by field.
// ----------------------------------------------------------------------------
module height_checker
  import htri_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  htri_req_if  req_i,
  htri_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [HeightBits-1:0] height;
    logic                         is_answer;
    logic                         range_error;
  } lookup_rsp_t;

  logic signed [HeightBits-1:0] corner_h [CornerDepth];
  logic signed [HeightBits-1:0] center_h [CenterDepth];
  lookup_rsp_t                  owed_rsp [$];
  int                           fails = 0;

  // Plane through the cell center and the two chosen corners, truncated
  // toward zero and saturated to the height range.
  function automatic logic signed [HeightBits-1:0] surface_height(
    input logic [QueryBits-1:0] qx,
    input logic [QueryBits-1:0] qz
  );
    longint xc, zc, lx, lz, h0, h1, h2, dy1, dy2, p, q, sum, mag;
    longint sx1, sz1, sx2, sz2, orient;
    xc = longint'(qx) >> FracBits;
    zc = longint'(qz) >> FracBits;
    if (xc > CellMax) xc = CellMax;
    if (zc > CellMax) zc = CellMax;
    lx = longint'(qx) - xc * Unit;
    lz = longint'(qz) - zc * Unit;
    h0 = center_h[xc * GridCells + zc];
    if (lx > lz) begin
      sx1 = 1;  sz1 = -1;
      h1 = corner_h[(xc + 1) * CornerSide + zc];
    end else begin
      sx1 = -1; sz1 = 1;
      h1 = corner_h[xc * CornerSide + zc + 1];
    end
    if (lz > Unit - lx) begin
      sx2 = 1;  sz2 = 1;
      h2 = corner_h[(xc + 1) * CornerSide + zc + 1];
    end else begin
      sx2 = -1; sz2 = -1;
      h2 = corner_h[xc * CornerSide + zc];
    end
    dy1 = h1 - h0;
    dy2 = h2 - h0;
    p = dy1 * sz2 - sz1 * dy2;
    q = sx1 * dy2 - dy1 * sx2;
    orient = sz1 * sx2 - sx1 * sz2;
    if (orient > 0) begin
      p = -p;
      q = -q;
    end
    sum = h0 * Unit + p * (lx - Half) + q * (lz - Half);
    if (sum < 0) begin
      mag = (-sum) >>> FracBits;
      if (mag > (64'sd1 <<< (HeightBits - 1))) mag = 64'sd1 <<< (HeightBits - 1);
      return HeightBits'(-mag);
    end
    mag = sum >>> FracBits;
    if (mag > (64'sd1 <<< (HeightBits - 1)) - 1) mag = (64'sd1 <<< (HeightBits - 1)) - 1;
    return HeightBits'(mag);
  endfunction

  function automatic lookup_rsp_t take_request(
    input logic [1:0]                   kind,
    input logic [IdxBits-1:0]           gx,
    input logic [IdxBits-1:0]           gz,
    input logic signed [HeightBits-1:0] hv,
    input logic [QueryBits-1:0]         qx,
    input logic [QueryBits-1:0]         qz
  );
    lookup_rsp_t r;
    r = '0;
    case (req_type_e'(kind))
      REQ_CORNER: begin
        if (gx <= GridCells && gz <= GridCells) corner_h[gx * CornerSide + gz] = hv;
        else r.range_error = 1'b1;
      end
      REQ_CENTER: begin
        if (gx < GridCells && gz < GridCells) center_h[gx * GridCells + gz] = hv;
        else r.range_error = 1'b1;
      end
      REQ_QUERY: begin
        r.height    = surface_height(qx, qz);
        r.is_answer = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    lookup_rsp_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        owed_rsp = {owed_rsp, take_request(req_i.req_type, req_i.grid_x, req_i.grid_z,
                                           req_i.height_value, req_i.query_x,
                                           req_i.query_z)};
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_rsp.size() == 0) begin
          $error("response transfer with no request outstanding");
          fails++;
        end else begin
          want = owed_rsp.pop_front();
          if (rsp_i.height_out !== want.height) begin
            $error("height_out: expected %0d, got %0d", want.height, rsp_i.height_out);
            fails++;
          end
          if (rsp_i.is_answer !== want.is_answer) begin
            $error("is_answer: expected %0b, got %0b", want.is_answer, rsp_i.is_answer);
            fails++;
          end
          if (rsp_i.range_error !== want.range_error) begin
            $error("range_error: expected %0b, got %0b", want.range_error,
                   rsp_i.range_error);
            fails++;
          end
        end
      end
    end
    owed_o       = owed_rsp.size();
    fail_count_o = fails;
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the terrain height lookup
// Drives height writes and (x,z) queries in random bursts, with a receiver
// that stalls on its own pattern and once holds off long enough to back up
// the pipeline. Every query only touches heights written before it. The
// scoreboard beside the block does the checking; this module gives verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import htri_pkg::*;

  localparam logic [1:0] ReqUnused   = 2'd3;
  localparam int         RandomItems = 1050;
  localparam int         StallHold   = 60;
  localparam int         DrainCycles = 12;
  localparam int         IdleLimit   = 2000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  htri_req_if req_if ();
  htri_rsp_if rsp_if ();

  int fail_count;
  int owed_count;
  bit corner_known [CornerDepth];
  bit center_known [CenterDepth];
  int items_sent  = 0;
  int burst_left  = 0;
  bit hold_wanted = 1'b0;

  heightmap_triangle_interpolation_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  height_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .owed_o       (owed_count)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    req_if.valid        <= 1'b0;
    req_if.req_type     <= '0;
    req_if.grid_x       <= '0;
    req_if.grid_z       <= '0;
    req_if.height_value <= '0;
    req_if.query_x      <= '0;
    req_if.query_z      <= '0;
    rsp_if.ready        <= 1'b0;
  end

  // watchdog: cycles with no transfer on either channel
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: segments of differing stall patterns, plus one long hold-off
  initial begin
    int seg_len, mode, tick;
    tick = 0;
    wait (rst_ni);
    forever begin
      seg_len = $urandom_range(20, 200);
      mode    = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk_i);
        tick++;
        if (hold_wanted) begin
          hold_wanted = 1'b0;
          rsp_if.ready <= 1'b0;
          repeat (StallHold) @(posedge clk_i);
          tick += StallHold;
        end
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= 1'($urandom_range(0, 1));
          2:       rsp_if.ready <= ($urandom_range(0, 9) != 0);
          default: rsp_if.ready <= ((tick % 7) >= 3);
        endcase
      end
    end
  end

  function automatic logic signed [HeightBits-1:0] rand_height();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       return {1'b0, {(HeightBits-1){1'b1}}};
          1:       return {1'b1, {(HeightBits-1){1'b0}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      2:       return HeightBits'($signed($urandom_range(0, 2000)) - 1000);
      default: return HeightBits'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic int pick_cell();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, CellMax);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 3);
    return $urandom_range(CellMax - 3, CellMax);
  endfunction

  task automatic xfer(input logic [1:0] kind, input logic [IdxBits-1:0] gx,
                      input logic [IdxBits-1:0] gz, input logic [HeightBits-1:0] hv,
                      input logic [QueryBits-1:0] qx, input logic [QueryBits-1:0] qz);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    burst_left--;
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.grid_x       <= gx;
    req_if.grid_z       <= gz;
    req_if.height_value <= hv;
    req_if.query_x      <= qx;
    req_if.query_z      <= qz;
    do @(posedge clk_i); while (!req_if.ready);
    if (kind == REQ_CORNER && gx <= GridCells && gz <= GridCells)
      corner_known[gx * CornerSide + gz] = 1'b1;
    if (kind == REQ_CENTER && gx < GridCells && gz < GridCells)
      center_known[gx * GridCells + gz] = 1'b1;
    items_sent++;
  endtask

  // query, preceded by writes of any height it reads that is not yet loaded
  task automatic ask(input int qx, input int qz);
    int xc, zc, lx, lz, cx1, cz1, cx2, cz2;
    xc = qx >> FracBits;
    zc = qz >> FracBits;
    if (xc > CellMax) xc = CellMax;
    if (zc > CellMax) zc = CellMax;
    lx = qx - xc * Unit;
    lz = qz - zc * Unit;
    if (lx > lz) begin
      cx1 = xc + 1; cz1 = zc;
    end else begin
      cx1 = xc;     cz1 = zc + 1;
    end
    if (lz > Unit - lx) begin
      cx2 = xc + 1; cz2 = zc + 1;
    end else begin
      cx2 = xc;     cz2 = zc;
    end
    if (!center_known[xc * GridCells + zc])
      xfer(REQ_CENTER, xc, zc, rand_height(), $urandom, $urandom);
    if (!corner_known[cx1 * CornerSide + cz1])
      xfer(REQ_CORNER, cx1, cz1, rand_height(), $urandom, $urandom);
    if (!corner_known[cx2 * CornerSide + cz2])
      xfer(REQ_CORNER, cx2, cz2, rand_height(), $urandom, $urandom);
    xfer(REQ_QUERY, $urandom, $urandom, $urandom, qx, qz);
  endtask

  initial begin
    int start, qx, qz, xc, zc, lx, lz, gx, gz;
    logic [1:0] kind;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: all four triangles, both tie lines, extremes, bad writes, unused type
    xfer(REQ_CORNER, 0, 0, {1'b1, {(HeightBits-1){1'b0}}}, '1, '1);
    xfer(REQ_CENTER, 0, 0, {1'b0, {(HeightBits-1){1'b1}}}, '0, '0);
    xfer(REQ_CORNER, 1, 0, 256, $urandom, $urandom);
    xfer(REQ_CORNER, 0, 1, -256, $urandom, $urandom);
    xfer(REQ_CORNER, 1, 1, -1, $urandom, $urandom);
    ask(128, 128);
    ask(0, 0);
    ask(230, 200);
    ask(200, 230);
    ask(100, 20);
    ask(20, 100);
    ask(100, 100);
    ask(100, 156);
    xfer(REQ_CENTER, CellMax, CellMax, {1'b1, {(HeightBits-1){1'b0}}}, $urandom, $urandom);
    xfer(REQ_CORNER, GridCells, GridCells, {1'b0, {(HeightBits-1){1'b1}}}, '1, '1);
    ask(65535, 65535);
    ask(32768, 32768);
    ask(0, 65535);
    xfer(REQ_CORNER, GridCells + 1, 0, $urandom, $urandom, $urandom);
    xfer(REQ_CORNER, 0, 255, $urandom, $urandom, $urandom);
    xfer(REQ_CENTER, GridCells, 5, $urandom, $urandom, $urandom);
    xfer(REQ_CENTER, 3, GridCells, $urandom, $urandom, $urandom);
    xfer(ReqUnused, $urandom, $urandom, $urandom, $urandom, $urandom);

    // random: mostly queries with their heights loaded first
    hold_wanted = 1'b1;
    burst_left  = 80;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          case ($urandom_range(0, 7))
            0: begin
              qx = $urandom_range(0, 65535);
              qz = $urandom_range(0, 65535);
            end
            1: begin
              qx = $urandom_range(32768, 65535);
              qz = $urandom_range(0, 32768);
            end
            2: begin
              qx = $urandom_range(0, 32768);
              qz = $urandom_range(32768, 65535);
            end
            default: begin
              xc = pick_cell();
              zc = pick_cell();
              lx = $urandom_range(0, Unit - 1);
              case ($urandom_range(0, 3))
                0:       lz = lx;
                1:       lz = Unit - lx;
                default: lz = $urandom_range(0, Unit - 1);
              endcase
              qx = xc * Unit + lx;
              qz = zc * Unit + lz;
            end
          endcase
          ask(qx, qz);
        end
        11, 12, 13: begin
          xfer(REQ_CORNER, pick_cell() + $urandom_range(0, 1),
               pick_cell() + $urandom_range(0, 1), rand_height(), $urandom, $urandom);
        end
        14, 15: xfer(REQ_CENTER, pick_cell(), pick_cell(), rand_height(), $urandom, $urandom);
        16, 17, 18: begin
          kind = $urandom_range(0, 1) ? REQ_CORNER : REQ_CENTER;
          gx = $urandom_range(0, (kind == REQ_CORNER) ? GridCells : CellMax);
          gz = $urandom_range(0, (kind == REQ_CORNER) ? GridCells : CellMax);
          case ($urandom_range(0, 2))
            0:       gx = $urandom_range((kind == REQ_CORNER) ? GridCells + 1 : GridCells, 255);
            1:       gz = $urandom_range((kind == REQ_CORNER) ? GridCells + 1 : GridCells, 255);
            default: begin
              gx = $urandom_range(GridCells + 1, 255);
              gz = $urandom_range(GridCells + 1, 255);
            end
          endcase
          xfer(kind, gx, gz, $urandom, $urandom, $urandom);
        end
        default: xfer(ReqUnused, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
    end
    req_if.valid <= 1'b0;

    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/htri_pkg.sv
src/htri_req_if.sv
src/htri_rsp_if.sv
src/htri_ram.sv
src/htri_front.sv
src/htri_solve.sv
src/heightmap_triangle_interpolation_top.sv
tb/height_checker.sv
tb/testbench.sv
